// ===== hdl/tpdm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpdm_pkg
// Shared types and constants of the tactile pixel difference map.
// ----------------------------------------------------------------------------
`default_nettype none

package tpdm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE_LEVEL   = 3'd0;
  localparam logic [2:0] REG_GAIN_BLUE    = 3'd1;
  localparam logic [2:0] REG_GAIN_GREEN   = 3'd2;
  localparam logic [2:0] REG_GAIN_RED     = 3'd3;
  localparam logic [2:0] REG_MARKER_THR   = 3'd4;
  localparam logic [2:0] REG_CHAN_LIMIT   = 3'd5;
  localparam logic [2:0] REG_SUM_OFFSET   = 3'd6;
  localparam logic [2:0] REG_SUM_GAIN     = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [7:0]        RST_BASE_LEVEL = 8'd12;
  localparam logic [9:0]        RST_GAIN_BLUE  = 10'd333;
  localparam logic [9:0]        RST_GAIN_GREEN = 10'd320;
  localparam logic [9:0]        RST_GAIN_RED   = 10'd282;
  localparam logic signed [8:0] RST_MARKER_THR = -9'sd5;
  localparam logic [7:0]        RST_CHAN_LIMIT = 8'd128;
  localparam logic [7:0]        RST_SUM_OFFSET = 8'd10;
  localparam logic [9:0]        RST_SUM_GAIN   = 10'd384;

  localparam logic [7:0] PIXEL_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] frame_blue;
    logic [7:0] frame_green;
    logic [7:0] frame_red;
    logic [7:0] back_blue;
    logic [7:0] back_green;
    logic [7:0] back_red;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [7:0] diff_blue;
    logic [7:0] diff_green;
    logic [7:0] diff_red;
    logic [7:0] diff_combined;
    logic       marker_hit;
    logic       frame_done;
  } out_item_t;

  // Settings that each channel unit needs.
  typedef struct packed {
    logic [9:0] gain;
    logic [7:0] base;
    logic [7:0] limit;
  } chan_cfg_t;

  // Flags that travel with an item down the pipeline.
  typedef struct packed {
    logic marker;
    logic eof;
  } side_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

endpackage

`default_nettype wire

// ===== hdl/tpdm_chan.sv =====
// ----------------------------------------------------------------------------
// tpdm_chan
// One color channel: difference, gain multiply, offset and clamp, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdm_chan
  import tpdm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [7:0] frame_px,
  input  wire logic [7:0] back_px,
  input  wire chan_cfg_t  cfg,
  output logic [7:0]      result
);

  logic signed [8:0]  diff_r, diff_nxt;
  logic signed [19:0] prod_r, prod_nxt;
  logic [7:0]         res_r, res_nxt;
  logic signed [19:0] acc;
  logic signed [19:0] lim;

  always_comb begin
    diff_nxt = $signed({1'b0, frame_px}) - $signed({1'b0, back_px});
    prod_nxt = $signed({1'b0, cfg.gain}) * diff_r;
  end

  // The clamp bounds are whole multiples of 256, so clamping before the
  // shift gives the same as clamping after it.
  always_comb begin
    acc = $signed({4'b0000, cfg.base, 8'h00}) + prod_r;
    lim = $signed({4'b0000, cfg.limit, 8'h00});
    if (acc > lim) begin
      res_nxt = cfg.limit;
    end else if (acc < 0) begin
      res_nxt = 8'd0;
    end else begin
      res_nxt = acc[15:8];
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign result = res_r;

endmodule

`default_nettype wire

// ===== hdl/tactile_pixel_diff_map_unit.sv =====
// ----------------------------------------------------------------------------
// tactile_pixel_diff_map_unit
// Per-pixel difference maps of a tactile camera frame against its background.
// ----------------------------------------------------------------------------
// Pipeline: six register stages (difference, multiply, clamp, channel sum,
// sum multiply, output) lie between an accepted item and its out_valid strobe.
// Throughput: one item per clock; busy is always low and the output side
// cannot stall, so the pipeline never holds.
// Reset: synchronous, active low; clears the valid bits, loads config defaults.
`default_nettype none

module tactile_pixel_diff_map_unit
  import tpdm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input items
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_data,
  // Result items
  output logic            out_valid,
  output out_item_t       out_data,
  // Configuration writes
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers. The user must change them only while the pipeline is
  // empty, which the block does not enforce; every stage reads them directly.
  // --------------------------------------------------------------------------
  logic [7:0]        base_level_r;
  logic [9:0]        gain_blue_r;
  logic [9:0]        gain_green_r;
  logic [9:0]        gain_red_r;
  logic signed [8:0] marker_thr_r;
  logic [7:0]        chan_limit_r;
  logic [7:0]        sum_offset_r;
  logic [9:0]        sum_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_level_r <= RST_BASE_LEVEL;
      gain_blue_r  <= RST_GAIN_BLUE;
      gain_green_r <= RST_GAIN_GREEN;
      gain_red_r   <= RST_GAIN_RED;
      marker_thr_r <= RST_MARKER_THR;
      chan_limit_r <= RST_CHAN_LIMIT;
      sum_offset_r <= RST_SUM_OFFSET;
      sum_gain_r   <= RST_SUM_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_LEVEL: base_level_r <= cfg_wdata[7:0];
        REG_GAIN_BLUE:  gain_blue_r  <= cfg_wdata;
        REG_GAIN_GREEN: gain_green_r <= cfg_wdata;
        REG_GAIN_RED:   gain_red_r   <= cfg_wdata;
        REG_MARKER_THR: marker_thr_r <= $signed(cfg_wdata[8:0]);
        REG_CHAN_LIMIT: chan_limit_r <= cfg_wdata[7:0];
        REG_SUM_OFFSET: sum_offset_r <= cfg_wdata[7:0];
        REG_SUM_GAIN:   sum_gain_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline advances every cycle, so the block is never busy.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // Valid bits, one per stage.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vo_r <= v5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: marker classification on the blue difference. The flag then
  // rides alongside the channel units for two more stages.
  // --------------------------------------------------------------------------
  logic signed [8:0] dblue;
  side_t side1_r, side1_nxt, side2_r, side3_r, side4_r, side5_r;

  always_comb begin
    dblue            = $signed({1'b0, in_data.frame_blue}) - $signed({1'b0, in_data.back_blue});
    side1_nxt.marker = dblue < marker_thr_r;
    side1_nxt.eof    = in_data.end_of_frame;
  end

  // --------------------------------------------------------------------------
  // Stages 1 to 3: the three channel units, each registering its difference,
  // its gain product and its clamped result.
  // --------------------------------------------------------------------------
  chan_cfg_t  cfg_blue, cfg_green, cfg_red;
  logic [7:0] res_blue, res_green, res_red;
  bgr_t       ch3;

  assign cfg_blue  = '{gain: gain_blue_r,  base: base_level_r, limit: chan_limit_r};
  assign cfg_green = '{gain: gain_green_r, base: base_level_r, limit: chan_limit_r};
  assign cfg_red   = '{gain: gain_red_r,   base: base_level_r, limit: chan_limit_r};

  tpdm_chan u_chan_blue (
    .clk      (clk),
    .frame_px (in_data.frame_blue),
    .back_px  (in_data.back_blue),
    .cfg      (cfg_blue),
    .result   (res_blue)
  );

  tpdm_chan u_chan_green (
    .clk      (clk),
    .frame_px (in_data.frame_green),
    .back_px  (in_data.back_green),
    .cfg      (cfg_green),
    .result   (res_green)
  );

  tpdm_chan u_chan_red (
    .clk      (clk),
    .frame_px (in_data.frame_red),
    .back_px  (in_data.back_red),
    .cfg      (cfg_red),
    .result   (res_red)
  );

  assign ch3 = '{blue: res_blue, green: res_green, red: res_red};

  // --------------------------------------------------------------------------
  // Stage 4: sum of the two largest channels (total minus the smallest),
  // less the offset. The result ranges from -255 to 510.
  // --------------------------------------------------------------------------
  logic [7:0]         ch_min;
  logic [9:0]         top_two;
  logic signed [10:0] sdiff_r, sdiff_nxt;
  bgr_t               ch4_r, ch5_r;

  always_comb begin
    ch_min = (ch3.blue < ch3.green) ? ch3.blue : ch3.green;
    if (ch3.red < ch_min) begin
      ch_min = ch3.red;
    end
    top_two   = {2'b00, ch3.blue} + {2'b00, ch3.green} + {2'b00, ch3.red}
              - {2'b00, ch_min};
    sdiff_nxt = $signed({1'b0, top_two}) - $signed({3'b000, sum_offset_r});
  end

  // --------------------------------------------------------------------------
  // Stage 5: combined gain multiply, Q2.8.
  // --------------------------------------------------------------------------
  logic signed [20:0] sprod_r, sprod_nxt;

  assign sprod_nxt = sdiff_r * $signed({1'b0, sum_gain_r});

  // --------------------------------------------------------------------------
  // Output stage: floor at zero, drop the fraction, saturate at 255, and
  // replace everything by the base level on marker pixels.
  // --------------------------------------------------------------------------
  logic [7:0] comb_val;
  out_item_t  out_r, out_nxt;

  always_comb begin
    if (sprod_r < 0) begin
      comb_val = 8'd0;
    end else if (sprod_r[19:16] != 4'd0) begin
      comb_val = PIXEL_MAX;
    end else begin
      comb_val = sprod_r[15:8];
    end

    if (side5_r.marker) begin
      out_nxt.diff_blue     = base_level_r;
      out_nxt.diff_green    = base_level_r;
      out_nxt.diff_red      = base_level_r;
      out_nxt.diff_combined = base_level_r;
    end else begin
      out_nxt.diff_blue     = ch5_r.blue;
      out_nxt.diff_green    = ch5_r.green;
      out_nxt.diff_red      = ch5_r.red;
      out_nxt.diff_combined = comb_val;
    end
    out_nxt.marker_hit = side5_r.marker;
    out_nxt.frame_done = side5_r.eof;
  end

  // Payload registers; they need no reset since the valid bits qualify them.
  always_ff @(posedge clk) begin
    side1_r <= side1_nxt;
    side2_r <= side1_r;
    side3_r <= side2_r;
    side4_r <= side3_r;
    side5_r <= side4_r;
    ch4_r   <= ch3;
    ch5_r   <= ch4_r;
    sdiff_r <= sdiff_nxt;
    sprod_r <= sprod_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Every result traces back to an accepted item.
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result without a matching accepted item");

  // Marker pixels report the same level on every map.
  a_marker_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.marker_hit) |->
      (out_data.diff_blue == out_data.diff_green &&
       out_data.diff_green == out_data.diff_red &&
       out_data.diff_red == out_data.diff_combined))
    else $error("marker pixel maps differ");

  // Channel maps of ordinary pixels never exceed the channel limit.
  a_chan_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.marker_hit) |->
      (out_data.diff_blue <= chan_limit_r &&
       out_data.diff_green <= chan_limit_r &&
       out_data.diff_red <= chan_limit_r))
    else $error("channel map above limit");
`endif

endmodule

`default_nettype wire

// ===== bench/tpdm_map_checker.sv =====
// ----------------------------------------------------------------------------
// tpdm_map_checker
// Watches the pixel and result channels of the difference map unit, predicts
// every result from its own copy of the settings and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpdm_map_checker
  import tpdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_wdata,
  output int         mismatch_count,
  output int         pending_maps
);

  logic [7:0]        base_level;
  logic [9:0]        gain_blue;
  logic [9:0]        gain_green;
  logic [9:0]        gain_red;
  logic signed [8:0] marker_thr;
  logic [7:0]        channel_limit;
  logic [7:0]        sum_offset;
  logic [9:0]        sum_gain;

  out_item_t expected_maps[$];

  function automatic logic [7:0] channel_map(input logic [7:0] fr, input logic [7:0] bk,
                                             input logic [9:0] gain);
    longint diff;
    longint acc;
    longint lim;
    diff = longint'(fr) - longint'(bk);
    acc  = longint'(base_level) * 256 + longint'(gain) * diff;
    lim  = longint'(channel_limit) * 256;
    if (acc > lim) acc = lim;
    if (acc < 0) acc = 0;
    return 8'(acc >>> 8);
  endfunction

  function automatic out_item_t predict_maps(input in_item_t px);
    out_item_t res;
    int        dblue;
    int        thr;
    int        b;
    int        g;
    int        r;
    int        mn;
    longint    p;
    dblue = int'(px.frame_blue) - int'(px.back_blue);
    thr   = int'(marker_thr);
    res.frame_done = px.end_of_frame;
    if (dblue < thr) begin
      res.diff_blue     = base_level;
      res.diff_green    = base_level;
      res.diff_red      = base_level;
      res.diff_combined = base_level;
      res.marker_hit    = 1'b1;
    end else begin
      b  = int'(channel_map(px.frame_blue, px.back_blue, gain_blue));
      g  = int'(channel_map(px.frame_green, px.back_green, gain_green));
      r  = int'(channel_map(px.frame_red, px.back_red, gain_red));
      mn = (b < g) ? b : g;
      if (r < mn) mn = r;
      p = longint'(b + g + r - mn - int'(sum_offset)) * longint'(sum_gain);
      if (p < 0) p = 0;
      p = p >>> 8;
      if (p > 255) p = 255;
      res.diff_blue     = 8'(b);
      res.diff_green    = 8'(g);
      res.diff_red      = 8'(r);
      res.diff_combined = 8'(p);
      res.marker_hit    = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      base_level     = RST_BASE_LEVEL;
      gain_blue      = RST_GAIN_BLUE;
      gain_green     = RST_GAIN_GREEN;
      gain_red       = RST_GAIN_RED;
      marker_thr     = RST_MARKER_THR;
      channel_limit  = RST_CHAN_LIMIT;
      sum_offset     = RST_SUM_OFFSET;
      sum_gain       = RST_SUM_GAIN;
      mismatch_count = 0;
      expected_maps.delete();
    end else begin
      // Results are checked before the new item is queued, so a result can
      // never be matched against an item accepted at the same edge.
      if (out_valid) begin
        if (expected_maps.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result with no item outstanding: b=%0d g=%0d r=%0d c=%0d m=%0b f=%0b",
                     $realtime, out_data.diff_blue, out_data.diff_green, out_data.diff_red,
                     out_data.diff_combined, out_data.marker_hit, out_data.frame_done);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_maps.pop_front();
          if (out_data.diff_blue !== want.diff_blue ||
              out_data.diff_green !== want.diff_green ||
              out_data.diff_red !== want.diff_red ||
              out_data.diff_combined !== want.diff_combined ||
              out_data.marker_hit !== want.marker_hit ||
              out_data.frame_done !== want.frame_done) begin
            if (mismatch_count < 10) begin
              $display("%0t: mismatch: expected b=%0d g=%0d r=%0d c=%0d m=%0b f=%0b",
                       $realtime, want.diff_blue, want.diff_green, want.diff_red,
                       want.diff_combined, want.marker_hit, want.frame_done);
              $display("%0t:           got b=%0d g=%0d r=%0d c=%0d m=%0b f=%0b",
                       $realtime, out_data.diff_blue, out_data.diff_green,
                       out_data.diff_red, out_data.diff_combined,
                       out_data.marker_hit, out_data.frame_done);
            end
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_maps.push_back(predict_maps(in_data));
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_LEVEL: base_level    = cfg_wdata[7:0];
          REG_GAIN_BLUE:  gain_blue     = cfg_wdata;
          REG_GAIN_GREEN: gain_green    = cfg_wdata;
          REG_GAIN_RED:   gain_red      = cfg_wdata;
          REG_MARKER_THR: marker_thr    = cfg_wdata[8:0];
          REG_CHAN_LIMIT: channel_limit = cfg_wdata[7:0];
          REG_SUM_OFFSET: sum_offset    = cfg_wdata[7:0];
          REG_SUM_GAIN:   sum_gain      = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending_maps <= expected_maps.size();
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the tactile pixel difference map unit: directed corner pixels,
// then phases of random pixels under extreme and random settings, with the
// sender idling at different rates. A checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tpdm_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [9:0] cfg_wdata;
  int         mismatch_count;
  int         pending_maps;

  // Threshold currently loaded, so random pixels can aim at its edge.
  int         cur_thr;

  always #6 clk = ~clk;

  tactile_pixel_diff_map_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tpdm_map_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_maps   (pending_maps)
  );

  function automatic in_item_t make_pixel(input logic [7:0] fb, input logic [7:0] fg,
                                          input logic [7:0] fr, input logic [7:0] bb,
                                          input logic [7:0] bg, input logic [7:0] br,
                                          input logic eof);
    in_item_t px;
    px.frame_blue   = fb;
    px.frame_green  = fg;
    px.frame_red    = fr;
    px.back_blue    = bb;
    px.back_green   = bg;
    px.back_red     = br;
    px.end_of_frame = eof;
    return px;
  endfunction

  function automatic logic [7:0] clip_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] corner_byte();
    case ($urandom_range(2))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Random pixel. Half of the pixels sit near the background or near the marker
  // threshold, since that is where the clamps and the marker decision bite;
  // the rest are fully random or made mostly of extreme bytes.
  function automatic in_item_t random_pixel(input int thr);
    in_item_t px;
    int       bb;
    bb = $urandom_range(255);
    px = make_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'(bb), 8'($urandom_range(255)),
                    8'($urandom_range(255)), ($urandom_range(15) == 0));
    case ($urandom_range(3))
      0: ;
      1: begin
        px.frame_blue  = clip_byte(int'(px.back_blue) + $urandom_range(40) - 20);
        px.frame_green = clip_byte(int'(px.back_green) + $urandom_range(40) - 20);
        px.frame_red   = clip_byte(int'(px.back_red) + $urandom_range(40) - 20);
      end
      2: begin
        px.frame_blue = clip_byte(bb + thr + $urandom_range(4) - 2);
      end
      default: begin
        px.frame_blue  = corner_byte();
        px.frame_green = corner_byte();
        px.frame_red   = corner_byte();
        px.back_blue   = corner_byte();
        px.back_green  = corner_byte();
        px.back_red    = corner_byte();
      end
    endcase
    return px;
  endfunction

  // Present one item and hold it until the block takes it. Start stays high
  // afterwards so that back-to-back items stream at full rate.
  task automatic send_pixel(input in_item_t px);
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idle the sender for a random number of cycles; each cycle is idle with
  // the given chance in a hundred.
  task automatic pause_sender(input int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_maps != 0) @(posedge clk);
  endtask

  // Settings may only change while the pipeline is empty: wait for every
  // result, then let the six pipeline stages run dry with some margin.
  task automatic drain_pipeline();
    wait_for_results();
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [9:0] base, input logic [9:0] gb,
                                input logic [9:0] gg, input logic [9:0] gr,
                                input logic [9:0] thr, input logic [9:0] lim,
                                input logic [9:0] offs, input logic [9:0] sg);
    logic signed [8:0] thr9;
    write_reg(REG_BASE_LEVEL, base);
    write_reg(REG_GAIN_BLUE, gb);
    write_reg(REG_GAIN_GREEN, gg);
    write_reg(REG_GAIN_RED, gr);
    write_reg(REG_MARKER_THR, thr);
    write_reg(REG_CHAN_LIMIT, lim);
    write_reg(REG_SUM_OFFSET, offs);
    write_reg(REG_SUM_GAIN, sg);
    cfg_we <= 1'b0;
    thr9 = thr[8:0];
    cur_thr = int'(thr9);
    @(posedge clk);
  endtask

  // A threshold mostly inside its stated range, now and then any 9-bit value.
  function automatic logic [9:0] random_thr();
    int v;
    if ($urandom_range(3) == 0) return 10'($urandom_range(1023));
    v = -int'($urandom_range(255));
    return 10'(v) | (10'($urandom_range(1)) << 9);
  endfunction

  initial begin
    in_item_t directed[$];
    int       idle_pct;

    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_BASE_LEVEL;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    cur_thr    = int'(RST_MARKER_THR);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels under the reset settings (threshold -5, limit 128).
    directed.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    directed.push_back(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    // Large positive differences hit the channel limit and saturate the sum.
    directed.push_back(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0));
    directed.push_back(make_pixel(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    // Blue far below the background: marker area.
    directed.push_back(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0));
    // Blue difference exactly at the threshold is not marker; one below is.
    directed.push_back(make_pixel(8'd100, 8'd90, 8'd80, 8'd105, 8'd70, 8'd60, 1'b0));
    directed.push_back(make_pixel(8'd100, 8'd90, 8'd80, 8'd106, 8'd70, 8'd60, 1'b1));
    // Green and red far below background floor at zero.
    directed.push_back(make_pixel(8'd50, 8'd0, 8'd0, 8'd50, 8'd255, 8'd255, 1'b0));
    // Sum of the two largest below the offset: combined map floors at zero.
    directed.push_back(make_pixel(8'd95, 8'd0, 8'd0, 8'd100, 8'd255, 8'd255, 1'b0));
    // Small differences around the background.
    directed.push_back(make_pixel(8'd11, 8'd21, 8'd31, 8'd10, 8'd20, 8'd30, 1'b0));
    directed.push_back(make_pixel(8'd9, 8'd19, 8'd29, 8'd10, 8'd20, 8'd30, 1'b1));
    directed.push_back(make_pixel(8'd128, 8'd0, 8'd255, 8'd127, 8'd255, 8'd0, 1'b0));
    directed.push_back(make_pixel(8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 1'b1));
    directed.push_back(make_pixel(8'd85, 8'd170, 8'd85, 8'd80, 8'd85, 8'd170, 1'b0));
    foreach (directed[i]) send_pixel(directed[i]);
    drain_pipeline();

    // Random phases, each under its own settings and sender idle rate.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ;  // reset settings
        1: apply_settings(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h0FF, 10'h3FF,
                          10'h3FF, 10'h3FF);
        2: apply_settings(10'h000, 10'h000, 10'h000, 10'h000, 10'h100, 10'h000,
                          10'h000, 10'h000);
        3: apply_settings(10'd0, 10'd512, 10'd256, 10'd128, 10'd0, 10'd255,
                          10'd0, 10'd256);
        default: apply_settings(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                random_thr(), 10'($urandom_range(1023)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023)));
      endcase
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 0;
        default: idle_pct = 24;
      endcase
      for (int n = 0; n < 200; n++) begin
        pause_sender(idle_pct);
        // Now and then hold the sender until every result is back.
        if ($urandom_range(149) == 0) wait_for_results();
        send_pixel(random_pixel(cur_thr));
      end
      drain_pipeline();
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tpdm_pkg.sv
hdl/tpdm_chan.sv
hdl/tactile_pixel_diff_map_unit.sv
bench/tpdm_map_checker.sv
bench/tb.sv
